### rtl/core/mra_pkg.sv
// ----------------------------------------------------------------------------
// Mapping region allocator package
// Shared types, constants and codes for the mapping region allocator.
// ----------------------------------------------------------------------------
package mra_pkg;

	localparam int MAX_MAPPINGS = 32;
	localparam int PAGE_BYTES   = 4096;
	localparam int OPEN_FILES   = 16;
	localparam int PAGE_BITS    = $clog2(PAGE_BYTES);
	localparam int IDX_W        = $clog2(MAX_MAPPINGS);
	localparam int CNT_W        = $clog2(MAX_MAPPINGS + 1);

	localparam logic [31:0] AREA_START_RESET = 32'h6000_0000;
	localparam logic [31:0] AREA_END_RESET   = 32'h8000_0000;

	localparam logic CFG_AREA_START = 1'b0;
	localparam logic CFG_AREA_END   = 1'b1;

	localparam logic KIND_MAP   = 1'b0;
	localparam logic KIND_UNMAP = 1'b1;

	typedef enum logic [3:0] {
		ST_OK         = 4'd0,
		ST_BAD_LENGTH = 4'd1,
		ST_BAD_ADDR   = 4'd2,
		ST_NO_SHARE   = 4'd3,
		ST_ANON_ARGS  = 4'd4,
		ST_BAD_FD     = 4'd5,
		ST_MISALIGNED = 4'd6,
		ST_NO_SPACE   = 4'd7,
		ST_NOT_FOUND  = 4'd8
	} status_t;

	typedef struct packed {
		logic               kind;
		logic        [31:0] req_address;
		logic signed [31:0] req_length;
		logic               want_shared;
		logic               want_private;
		logic               want_anonymous;
		logic               want_fixed;
		logic signed  [7:0] descriptor;
		logic               file_offset_nonzero;
		logic               descriptor_open;
	} req_t;

	typedef struct packed {
		logic  [3:0] status;
		logic [31:0] result_address;
	} rsp_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT,
		S_DONE
	} state_t;

endpackage

### rtl/core/mapping_region_allocator.sv
// ----------------------------------------------------------------------------
// Mapping region allocator
// A request that needs no table walk goes from S_IDLE straight to S_DONE; the
// search reads one table entry per cycle, and unmap scans and compacts the
// table one entry per cycle. One request at a time; the next is taken once the
// response has been accepted.
// Reset clears the entry count and restores the area registers; no sweep.
// ----------------------------------------------------------------------------
module mapping_region_allocator (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  mra_pkg::req_t in_data,
	output logic          out_valid,
	input  logic          out_stall,
	output mra_pkg::rsp_t out_data,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic          cfg_index,
	input  logic [31:0]   cfg_data
);
	import mra_pkg::*;

	// Registers
	state_t            state_q, state_d;
	logic [31:0]       area_start_q, area_end_q;
	logic [CNT_W-1:0]  count_q;
	req_t              req_q;
	logic [CNT_W-1:0]  idx_q;
	logic [32:0]       cand_q;
	logic [31:0]       place_q;
	rsp_t              rsp_q;
	logic              out_valid_q;

	// Entry memories, one read port registered
	logic [31:0] mem_start [MAX_MAPPINGS];
	logic [30:0] mem_len   [MAX_MAPPINGS];
	logic [31:0] rd_start;
	logic [30:0] rd_len;
	logic        rd_ok_q;
	logic [IDX_W-1:0] rd_addr;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	logic [31:0]      wr_start;
	logic [30:0]      wr_len;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_start[wr_addr] <= wr_start;
			mem_len[wr_addr]   <= wr_len;
		end
		rd_start <= mem_start[rd_addr];
		rd_len   <= mem_len[rd_addr];
	end

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != S_IDLE) || out_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = rsp_q;

	// Front checks of a map request
	logic [31:0] a;
	logic        aligned;
	status_t     chk;
	always_comb begin
		a       = in_data.req_address;
		aligned = (a[PAGE_BITS-1:0] == '0);
		chk     = ST_OK;
		if (in_data.req_length <= 0)
			chk = ST_BAD_LENGTH;
		else if (a != 0 && (a < area_start_q ||
				({1'b0, a} + 33'(PAGE_BYTES)) > {1'b0, area_end_q} || !aligned))
			chk = ST_BAD_ADDR;
		else if (!in_data.want_shared && !in_data.want_private)
			chk = ST_NO_SHARE;
		else if (in_data.want_anonymous &&
				(in_data.descriptor != -8'sd1 || in_data.file_offset_nonzero))
			chk = ST_ANON_ARGS;
		else if (in_data.want_fixed && (a == 0 || !aligned))
			chk = ST_MISALIGNED;
		else if (!in_data.want_anonymous && (in_data.descriptor < 0 ||
				in_data.descriptor >= 8'(OPEN_FILES) || !in_data.descriptor_open))
			chk = ST_BAD_FD;
		else if (count_q >= CNT_W'(MAX_MAPPINGS))
			chk = ST_NO_SPACE;
	end

	// Shared compare unit on the registered entry
	logic [32:0] len33, cend, e_round, e_raw, step_tgt;
	logic        hit_map;
	logic signed [33:0] ua, ul, us, ue;
	logic        hit_unmap;
	always_comb begin
		len33   = {1'b0, req_q.req_length};
		cend    = cand_q + len33;
		e_raw   = {1'b0, rd_start} + {2'b0, rd_len};
		e_round = {1'b0, rd_start} +
			(({2'b0, rd_len} + 33'(PAGE_BYTES - 1)) & ~33'(PAGE_BYTES - 1));
		hit_map = ({1'b0, rd_start} < cend) && (e_round > cand_q);
		// new candidate = cand + ceil((e - cand)/page)*page
		step_tgt = cand_q + (((e_round - cand_q) + 33'(PAGE_BYTES - 1)) &
			~33'(PAGE_BYTES - 1));
		ua = {2'b0, req_q.req_address};
		ul = 34'(req_q.req_length);
		us = {2'b0, rd_start};
		ue = {1'b0, e_raw};
		hit_unmap = (ua >= us) && (ua + ul <= ue);
	end

	// Next state
	logic last;
	assign last = (idx_q + 1'b1 >= count_q);
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:  if (in_valid && !in_stall) begin
				if (in_data.kind == KIND_UNMAP) state_d = (count_q == 0) ? S_DONE : S_SCAN;
				else if (chk != ST_OK || in_data.want_fixed || count_q == 0) state_d = S_DONE;
				else state_d = S_SCAN;
			end
			S_SCAN:  if (rd_ok_q) begin
				if (req_q.kind == KIND_UNMAP) begin
					if (hit_unmap) state_d = S_SHIFT;
					else if (last) state_d = S_DONE;
				end else begin
					if (cend > {1'b0, area_end_q}) state_d = S_DONE;
					else if (!hit_map && last) state_d = S_DONE;
				end
			end
			S_SHIFT: if (last) state_d = S_DONE;
			S_DONE:  state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// Memory addressing; the walk always starts at entry 0
	always_comb begin
		rd_addr  = (state_q == S_IDLE) ? '0 : IDX_W'(idx_q);
		wr_en    = 1'b0;
		wr_addr  = IDX_W'(count_q);
		wr_start = place_q;
		wr_len   = req_q.req_length[30:0];
		if (state_q == S_SCAN && rd_ok_q && req_q.kind == KIND_MAP && hit_map)
			rd_addr = '0;
		else if (state_q == S_SCAN && rd_ok_q)
			rd_addr = IDX_W'(idx_q + 1'b1);
		if (state_q == S_SHIFT) begin
			rd_addr = IDX_W'(idx_q + 2'd2);
			if (!last) begin
				wr_en    = 1'b1;
				wr_addr  = IDX_W'(idx_q);
				wr_start = rd_start;
				wr_len   = rd_len;
			end
		end
		if (state_q == S_DONE && req_q.kind == KIND_MAP && rsp_q.status == ST_OK)
			wr_en = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			area_start_q <= AREA_START_RESET;
			area_end_q   <= AREA_END_RESET;
			count_q      <= '0;
			out_valid_q  <= 1'b0;
			rd_ok_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_index == CFG_AREA_START) area_start_q <= cfg_data;
			if (cfg_valid && cfg_index == CFG_AREA_END)   area_end_q   <= cfg_data;
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			if (state_q == S_DONE) begin
				out_valid_q <= 1'b1;
				if (rsp_q.status == ST_OK) begin
					if (req_q.kind == KIND_MAP) count_q <= count_q + 1'b1;
					else count_q <= count_q - 1'b1;
				end
			end
			rd_ok_q <= (state_d == S_SCAN);
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: if (in_valid && !in_stall) begin
				req_q  <= in_data;
				idx_q  <= '0;
				cand_q <= {1'b0, area_start_q};
				place_q <= in_data.want_fixed ? in_data.req_address : area_start_q;
				rsp_q.result_address <= '0;
				if (in_data.kind == KIND_UNMAP) rsp_q.status <= ST_NOT_FOUND;
				else if (chk != ST_OK) rsp_q.status <= chk;
				else if (in_data.want_fixed || count_q == 0) begin
					if (!in_data.want_fixed && ({1'b0, area_start_q} +
							{1'b0, in_data.req_length}) > {1'b0, area_end_q})
						rsp_q.status <= ST_NO_SPACE;
					else rsp_q.status <= ST_OK;
				end else rsp_q.status <= ST_NO_SPACE;
			end
			S_SCAN: if (rd_ok_q) begin
				if (req_q.kind == KIND_UNMAP) begin
					if (hit_unmap) rsp_q.status <= ST_OK;
					else idx_q <= idx_q + 1'b1;
				end else if (cend <= {1'b0, area_end_q}) begin
					if (hit_map) begin
						cand_q <= step_tgt;
						idx_q  <= '0;
					end else if (last) begin
						rsp_q.status <= ST_OK;
						place_q <= cand_q[31:0];
					end else idx_q <= idx_q + 1'b1;
				end
			end
			S_SHIFT: idx_q <= idx_q + 1'b1;
			S_DONE: if (req_q.kind == KIND_MAP && rsp_q.status == ST_OK)
				rsp_q.result_address <= place_q;
			default: ;
		endcase
	end

endmodule

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// Mapping region allocator testbench
// Drives map and unmap requests through the request channel and checks every
// response against its typed row or a predictor that keeps its own copy of the
// mapping table and area registers. A short directed table comes first, then
// random traffic over several area settings with random idling on both sides.
// ----------------------------------------------------------------------------
module tb;

	import mra_pkg::*;

	localparam int PHASE_ITEMS  = 250;
	localparam int NUM_PHASES   = 5;
	localparam int WATCHDOG_MAX = 20000;
	localparam int DRAIN_CYCLES = 80;
	localparam int HOLD_CYCLES  = 300;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	req_t        in_data;
	logic        out_valid;
	logic        out_stall;
	rsp_t        out_data;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_index;
	logic [31:0] cfg_data;

	// Predictor state: area registers and the mapping table.
	logic [31:0] area_lo;
	logic [31:0] area_hi;
	logic [31:0] map_start [MAX_MAPPINGS];
	logic [30:0] map_len [MAX_MAPPINGS];
	int          map_count;

	rsp_t        pending_rsp [$];
	int          fail_count;
	int          mismatch_count;
	int          sent_count;
	int          recv_count;
	int          idle_cycles;
	int          send_idle;
	int          recv_idle;
	bit          hold_done;

	typedef struct {
		req_t        req;
		bit          typed;
		status_t     st;
		logic [31:0] addr;
	} stim_row_t;

	mapping_region_allocator DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Clock generation.
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Build a request from its fields.
	function automatic req_t make_req(logic kind, logic [31:0] addr, logic [31:0] len,
			logic sh, logic pr, logic an, logic fx, logic [7:0] fd, logic off, logic op);
		req_t r;
		r.kind                = kind;
		r.req_address         = addr;
		r.req_length          = len;
		r.want_shared         = sh;
		r.want_private        = pr;
		r.want_anonymous      = an;
		r.want_fixed          = fx;
		r.descriptor          = fd;
		r.file_offset_nonzero = off;
		r.descriptor_open     = op;
		return r;
	endfunction

	// First-fit search over the area, stepping past overlapping entries.
	function automatic bit find_gap(longint unsigned len, output logic [31:0] at);
		longint unsigned cand;
		longint unsigned s;
		longint unsigned e;
		bit hit;
		cand = area_lo;
		at = '0;
		while (cand + len <= longint'(area_hi)) begin
			hit = 1'b0;
			for (int i = 0; i < map_count && !hit; i++) begin
				s = map_start[i];
				e = s + ((longint'(map_len[i]) + PAGE_BYTES - 1) / PAGE_BYTES) * PAGE_BYTES;
				if (s < cand + len && e > cand) begin
					cand += ((e - cand + PAGE_BYTES - 1) / PAGE_BYTES) * PAGE_BYTES;
					hit = 1'b1;
				end
			end
			if (!hit) begin
				at = cand[31:0];
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	// Work out the response to one request and update the predicted table.
	function automatic rsp_t allocate_predict(req_t r);
		rsp_t        p;
		logic [31:0] place;
		bit          aligned;
		longint      ua;
		longint      ul;
		longint      s;
		longint      e;
		bit          done;
		p.result_address = '0;
		aligned = (r.req_address % PAGE_BYTES) == 0;
		if (r.kind == KIND_MAP) begin
			if (r.req_length <= 0)
				p.status = ST_BAD_LENGTH;
			else if (r.req_address != 0 && (r.req_address < area_lo || !aligned ||
					longint'(r.req_address) + PAGE_BYTES > longint'(area_hi)))
				p.status = ST_BAD_ADDR;
			else if (!r.want_shared && !r.want_private)
				p.status = ST_NO_SHARE;
			else if (r.want_anonymous && (r.descriptor != -8'sd1 || r.file_offset_nonzero))
				p.status = ST_ANON_ARGS;
			else if (r.want_fixed && (r.req_address == 0 || !aligned))
				p.status = ST_MISALIGNED;
			else if (!r.want_anonymous && (r.descriptor < 0 ||
					r.descriptor >= OPEN_FILES || !r.descriptor_open))
				p.status = ST_BAD_FD;
			else if (map_count >= MAX_MAPPINGS)
				p.status = ST_NO_SPACE;
			else begin
				if (r.want_fixed) begin
					place = r.req_address;
					p.status = ST_OK;
				end else
					p.status = find_gap(longint'(r.req_length), place) ? ST_OK : ST_NO_SPACE;
				if (p.status == ST_OK) begin
					map_start[map_count] = place;
					map_len[map_count]   = r.req_length[30:0];
					map_count++;
					p.result_address = place;
				end
			end
		end else begin
			ua = longint'({32'b0, r.req_address});
			ul = longint'(r.req_length);
			done = 1'b0;
			for (int i = 0; i < map_count && !done; i++) begin
				s = longint'({32'b0, map_start[i]});
				e = s + longint'({33'b0, map_len[i]});
				if (ua >= s && ua + ul <= e) begin
					for (int k = i; k + 1 < map_count; k++) begin
						map_start[k] = map_start[k + 1];
						map_len[k]   = map_len[k + 1];
					end
					map_count--;
					done = 1'b1;
				end
			end
			p.status = done ? ST_OK : ST_NOT_FOUND;
		end
		return p;
	endfunction

	// Offer one request, with random gaps before it, and wait for acceptance.
	task automatic send_request(req_t r, bit typed, rsp_t typed_rsp);
		rsp_t p;
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			in_data  <= req_t'({$urandom, $urandom, $urandom});
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= r;
		do @(posedge clk); while (in_stall);
		p = allocate_predict(r);
		pending_rsp.push_back(typed ? typed_rsp : p);
		sent_count++;
		@(negedge clk);
	endtask

	// Write one area register while the block is idle.
	task automatic write_area(logic idx, logic [31:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_AREA_START)
			area_lo = value;
		else
			area_hi = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// Wait until every expected response has come back.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_rsp.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Random request, mostly well formed so that the table fills and empties.
	function automatic req_t random_request(int map_weight);
		int          sel;
		int          i;
		logic [31:0] base;
		logic [31:0] addr;
		logic [31:0] len;
		logic [31:0] off;
		logic        anon;
		logic        fx;
		sel = $urandom_range(99);
		base = (area_lo + PAGE_BYTES - 1) & ~(PAGE_BYTES - 1);
		if (sel < map_weight) begin
			anon = $urandom_range(3) != 0;
			fx   = $urandom_range(9) == 0;
			len  = ($urandom_range(9) == 0) ? ($urandom & 32'h7FFF_FFFF) :
				$urandom_range(1, 5 * PAGE_BYTES);
			addr = fx ? base + PAGE_BYTES * $urandom_range(0, 63) : 32'h0;
			if (fx && longint'(addr) + PAGE_BYTES > longint'(area_hi))
				addr = base;
			return make_req(KIND_MAP, addr, len, 1'($urandom_range(1)), 1'b1, anon, fx,
				anon ? 8'hFF : 8'($urandom_range(0, OPEN_FILES - 1)), 1'b0, 1'b1);
		end else if (sel < 88 && map_count > 0) begin
			i    = $urandom_range(0, map_count - 1);
			off  = $urandom_range(0, 3) == 0 ? $urandom_range(0, map_len[i]) : 0;
			addr = map_start[i] + off;
			len  = $urandom_range(0, 3) == 0 ? -$urandom_range(0, 64) :
				$urandom_range(0, map_len[i] - off);
			return make_req(KIND_UNMAP, addr, len, 1'($urandom), 1'($urandom), 1'($urandom),
				1'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
		end
		return req_t'({$urandom, $urandom, $urandom});
	endfunction

	// Receiver stall pattern, with one long hold-off while requests keep coming.
	initial begin
		out_stall = 1'b1;
		hold_done = 1'b0;
		forever begin
			@(negedge clk);
			if (!hold_done && recv_count == 100) begin
				hold_done = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			out_stall <= ($urandom_range(99) < recv_idle);
		end
	end

	// Response checking against the oldest expectation.
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && out_valid && !out_stall) begin
			recv_count++;
			if (pending_rsp.size() == 0) begin
				fail_count++;
				if (mismatch_count++ < 10)
					$display("response with no request outstanding: status %0d addr %h",
						out_data.status, out_data.result_address);
			end else begin
				want = pending_rsp.pop_front();
				if (out_data.status !== want.status ||
						out_data.result_address !== want.result_address) begin
					fail_count++;
					if (mismatch_count++ < 10)
						$display("mismatch: expected status %0d addr %h, got status %0d addr %h",
							want.status, want.result_address,
							out_data.status, out_data.result_address);
				end
			end
		end
	end

	// Watchdog on cycles with no accepted transfer.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else if (++idle_cycles >= WATCHDOG_MAX) begin
			$display("[mapping_region_allocator] ERROR");
			$finish;
		end
	end

	// Main stimulus sequence.
	initial begin
		stim_row_t   rows [$];
		logic [31:0] lo_set [NUM_PHASES];
		logic [31:0] hi_set [NUM_PHASES];
		int          weight [NUM_PHASES];
		int          n;
		rsp_t        t;
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		in_data        = '0;
		cfg_valid      = 1'b0;
		cfg_index      = CFG_AREA_START;
		cfg_data       = '0;
		area_lo        = AREA_START_RESET;
		area_hi        = AREA_END_RESET;
		map_count      = 0;
		fail_count     = 0;
		mismatch_count = 0;
		sent_count     = 0;
		recv_count     = 0;
		idle_cycles    = 0;
		send_idle      = 29;
		recv_idle      = 74;

		// Directed rows, starting from the reset area with an empty table.
		rows = '{
			'{make_req(KIND_MAP, 0, 0, 1, 1, 1, 0, 8'hFF, 0, 0), 1, ST_BAD_LENGTH, 0},
			'{make_req(KIND_MAP, 0, 32'hFFFF_FFFF, 1, 0, 1, 0, 8'hFF, 0, 0), 1, ST_BAD_LENGTH, 0},
			'{make_req(KIND_MAP, 0, 32'h8000_0000, 0, 1, 1, 0, 8'hFF, 0, 0), 1, ST_BAD_LENGTH, 0},
			'{make_req(KIND_MAP, 32'h5FFF_F000, 4096, 0, 1, 1, 0, 8'hFF, 0, 0), 1, ST_BAD_ADDR, 0},
			'{make_req(KIND_MAP, 32'h8000_0000, 4096, 0, 1, 1, 0, 8'hFF, 0, 0), 1, ST_BAD_ADDR, 0},
			'{make_req(KIND_MAP, 32'h6000_0001, 4096, 0, 1, 1, 0, 8'hFF, 0, 0), 1, ST_BAD_ADDR, 0},
			'{make_req(KIND_MAP, 0, 4096, 0, 0, 1, 0, 8'hFF, 0, 0), 1, ST_NO_SHARE, 0},
			'{make_req(KIND_MAP, 0, 4096, 0, 1, 1, 0, 8'd5, 0, 0), 1, ST_ANON_ARGS, 0},
			'{make_req(KIND_MAP, 0, 4096, 0, 1, 1, 0, 8'hFF, 1, 0), 1, ST_ANON_ARGS, 0},
			'{make_req(KIND_MAP, 0, 4096, 0, 1, 1, 1, 8'hFF, 0, 0), 1, ST_MISALIGNED, 0},
			'{make_req(KIND_MAP, 0, 4096, 1, 0, 0, 0, 8'hFF, 0, 1), 1, ST_BAD_FD, 0},
			'{make_req(KIND_MAP, 0, 4096, 1, 0, 0, 0, 8'd16, 0, 1), 1, ST_BAD_FD, 0},
			'{make_req(KIND_MAP, 0, 4096, 1, 0, 0, 0, 8'd3, 0, 0), 1, ST_BAD_FD, 0},
			'{make_req(KIND_MAP, 0, 4096, 1, 0, 0, 0, 8'd127, 0, 1), 1, ST_BAD_FD, 0},
			'{make_req(KIND_MAP, 0, 4096, 1, 0, 0, 0, 8'h80, 0, 1), 1, ST_BAD_FD, 0},
			'{make_req(KIND_MAP, 32'h7FFF_F000, 1, 0, 1, 1, 0, 8'hFF, 0, 0), 1, ST_OK,
				32'h6000_0000},
			'{make_req(KIND_MAP, 0, 32'h7FFF_FFFF, 1, 0, 1, 0, 8'hFF, 0, 0), 0, ST_OK, 0},
			'{make_req(KIND_MAP, 32'h6000_0000, 4096, 1, 1, 1, 1, 8'hFF, 0, 0), 1, ST_OK,
				32'h6000_0000},
			'{make_req(KIND_MAP, 0, 4096, 1, 0, 0, 0, 8'd0, 1, 1), 0, ST_OK, 0},
			'{make_req(KIND_MAP, 32'h7FFF_F000, 8192, 0, 1, 1, 1, 8'hFF, 0, 0), 0, ST_OK, 0},
			'{make_req(KIND_UNMAP, 32'h6000_0000, 1, 0, 0, 0, 0, 0, 0, 0), 1, ST_OK, 0},
			'{make_req(KIND_UNMAP, 32'h7000_0000, 4096, 0, 0, 0, 0, 0, 0, 0), 1, ST_NOT_FOUND, 0},
			'{make_req(KIND_UNMAP, 32'h6000_0000, -5, 0, 0, 0, 0, 0, 0, 0), 0, ST_OK, 0},
			'{make_req(KIND_UNMAP, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1, 1, 1, 1, 8'hFF, 1, 1), 1,
				ST_NOT_FOUND, 0}
		};

		// Area settings per random phase: the reset values, extremes, a small
		// unaligned area, a top-of-memory area and finally the reset values again.
		lo_set = '{32'h6000_0000, 32'h0000_0000, 32'h1000_0800, 32'hFFFF_F000, 32'h6000_0000};
		hi_set = '{32'h8000_0000, 32'hFFFF_FFFF, 32'h1004_0000, 32'hFFFF_FFFF, 32'h8000_0000};
		weight = '{55, 70, 60, 50, 40};

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (rows[i]) begin
			t.status         = rows[i].st;
			t.result_address = rows[i].addr;
			send_request(rows[i].req, rows[i].typed, t);
		end

		n = 0;
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			wait_drained();
			write_area(CFG_AREA_START, lo_set[ph]);
			write_area(CFG_AREA_END, hi_set[ph]);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if (n == 417) begin
					send_idle = 74;
					recv_idle = 29;
				end else if (n == 834) begin
					send_idle = 0;
					recv_idle = 0;
				end
				// One pause in the middle of a phase until everything is back.
				if (k == PHASE_ITEMS / 2 && ph == 1)
					wait_drained();
				send_request(random_request(weight[ph]), 1'b0, t);
				n++;
			end
		end

		in_valid <= 1'b0;
		while (pending_rsp.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0)
			$display("[mapping_region_allocator] OK");
		else
			$display("[mapping_region_allocator] ERROR");
		$finish;
	end

endmodule

### filelist.f
rtl/core/mra_pkg.sv
rtl/core/mapping_region_allocator.sv
tb/sv/tb.sv
